@@ rtl/ata_pio_command_sequencer_macros.svh @@
// assertion helpers for the ata pio command sequencer
// both expect clk and rst in scope and stay quiet while rst is high
`ifndef ATA_PIO_COMMAND_SEQUENCER_MACROS_SVH
`define ATA_PIO_COMMAND_SEQUENCER_MACROS_SVH

// same-cycle implication
`define ATA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ATA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ata_pkg.sv @@
// ----------------------------------------------------------------------------
// ata_pkg
// Types, codes and sizes shared by the ata pio command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ata_pkg;

  // sizes
  localparam int SECTOR_WORDS = 256;
  localparam int SETTLE_READS = 4;
  localparam int WORDS_W      = $clog2(255 * SECTOR_WORDS + 1);
  localparam int POLL_W       = 29;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_ROOM    = FIFO_DEPTH - 1;
  localparam int PTR_W        = $clog2(FIFO_DEPTH);
  localparam int CNT_W        = $clog2(FIFO_DEPTH + 1);
  localparam int TF_LEN_NARROW = 6;
  localparam int TF_LEN_WIDE   = 10;
  localparam int MAX_BURST     = TF_LEN_WIDE + 2;
  localparam int IDX_W         = $clog2(MAX_BURST);

  // input action codes
  localparam logic [2:0] ACT_READ   = 3'd0;
  localparam logic [2:0] ACT_WRITE  = 3'd1;
  localparam logic [2:0] ACT_STATUS = 3'd2;
  localparam logic [2:0] ACT_ERROR  = 3'd3;
  localparam logic [2:0] ACT_WORD   = 3'd4;

  // bus operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_HOST  = 2'd2;
  localparam logic [1:0] OP_DONE  = 2'd3;

  // task file register offsets
  localparam logic [2:0] OFF_DATA    = 3'd0;
  localparam logic [2:0] OFF_ERROR   = 3'd1;
  localparam logic [2:0] OFF_COUNT   = 3'd2;
  localparam logic [2:0] OFF_LBA_LO  = 3'd3;
  localparam logic [2:0] OFF_LBA_MID = 3'd4;
  localparam logic [2:0] OFF_LBA_HI  = 3'd5;
  localparam logic [2:0] OFF_DEVICE  = 3'd6;
  localparam logic [2:0] OFF_CMD     = 3'd7;

  // outcome codes
  localparam logic [2:0] OC_OK      = 3'd0;
  localparam logic [2:0] OC_RANGE   = 3'd1;
  localparam logic [2:0] OC_DEV_ERR = 3'd2;
  localparam logic [2:0] OC_FAULT   = 3'd3;
  localparam logic [2:0] OC_NO_DRQ  = 3'd4;
  localparam logic [2:0] OC_TIMEOUT = 3'd5;

  // config register indexes
  localparam logic [1:0] CFG_DRIVE   = 2'd0;
  localparam logic [1:0] CFG_WIDE    = 2'd1;
  localparam logic [1:0] CFG_HIGHEST = 2'd2;
  localparam logic [1:0] CFG_POLL    = 2'd3;

  // device register bits
  localparam logic [7:0] DEV_OBSOLETE = 8'hA0;
  localparam logic [7:0] DEV_LBA      = 8'h40;
  localparam logic [7:0] DEV_SLAVE    = 8'h10;

  // commands
  localparam logic [7:0] CMD_READ        = 8'h20;
  localparam logic [7:0] CMD_READ_EXT    = 8'h24;
  localparam logic [7:0] CMD_WRITE       = 8'h30;
  localparam logic [7:0] CMD_WRITE_EXT   = 8'h34;
  localparam logic [7:0] CMD_FLUSH       = 8'hE7;
  localparam logic [7:0] CMD_FLUSH_EXT   = 8'hEA;

  // status bit positions
  localparam int ST_BSY = 7;
  localparam int ST_DF  = 5;
  localparam int ST_DRQ = 3;
  localparam int ST_ERR = 0;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETTLE,
    PH_POLL,
    PH_ERRWAIT,
    PH_XFER
  } phase_t;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_DONE,
    TAIL_CMD
  } tail_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  off;
    logic [15:0] value;
    logic [2:0]  outcome;
    logic [7:0]  err;
  } result_t;

  // one burst of results caused by one input item
  typedef struct packed {
    logic        has_lead;
    result_t     lead;
    logic        tf;
    logic        wide;
    logic [7:0]  dev;
    logic [31:0] lba;
    logic [7:0]  cnt;
    tail_t       tail;
    logic [7:0]  cmd;
  } burst_t;

endpackage

`default_nettype wire

@@ rtl/ata_pio_command_sequencer.sv @@
// ----------------------------------------------------------------------------
// ata_pio_command_sequencer
// Host-side ATA PIO sequencer for LBA28 and LBA48 task files.
// ----------------------------------------------------------------------------
// An input item is taken every cycle while in_stall is low; it is registered,
// decoded against the sequencer state in the next cycle and turned into at most
// one burst descriptor in a four-entry queue. The first result is read from the
// queue head once the descriptor is written there. Results leave one per cycle
// while out_stall is low: a request expands into 8 (LBA28) or 12 (LBA48) task
// file transactions, other items into 0 to 3. The queue depth sets the input
// rate: data words stream at one per cycle as long as out_stall stays low, whereas
// a run of requests stalls the input whenever three or more bursts are queued.
`default_nettype none

`include "ata_pio_command_sequencer_macros.svh"

module ata_pio_command_sequencer
  import ata_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // input items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  action,
  input  wire logic [31:0] lba,
  input  wire logic [7:0]  sector_count,
  input  wire logic [7:0]  status_byte,
  input  wire logic [7:0]  error_byte,
  input  wire logic [15:0] data_word,
  // result items
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       bus_op,
  output logic [2:0]       port_offset,
  output logic [15:0]      bus_value,
  output logic [2:0]       outcome,
  output logic [7:0]       error_bits,
  output logic             last_of_run
);

  // configuration registers
  logic              drive_select;
  logic              wide_addressing;
  logic [31:0]       highest_lba;
  logic [POLL_W-1:0] poll_limit;

  // sequencer state
  phase_t             phase, phase_next;
  logic               write_pending, write_pending_next;
  logic               flushing, flushing_next;
  logic [WORDS_W-1:0] words_left, words_left_next;
  logic [POLL_W-1:0]  polls_left, polls_left_next;

  // input register
  logic        s1_valid;
  logic [2:0]  s1_action;
  logic [31:0] s1_lba;
  logic [7:0]  s1_cnt;
  logic [7:0]  s1_status;
  logic [7:0]  s1_error;
  logic [15:0] s1_word;

  // burst queue
  burst_t           fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  burst_t           burst_next;
  logic             push, pop;

  // output walker
  burst_t           head;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] lead_len, tf_len, tail_len, burst_len, rel, rel_tail;
  result_t          cur;
  logic             is_last;

  logic [7:0] dev_byte;

  function automatic result_t mk_result(logic [1:0] op, logic [2:0] off,
                                        logic [15:0] value, logic [2:0] oc,
                                        logic [7:0] err);
    result_t r;
    r.op      = op;
    r.off     = off;
    r.value   = value;
    r.outcome = oc;
    r.err     = err;
    return r;
  endfunction

  // one task file write of a request burst
  function automatic result_t tf_entry(logic wide, logic [7:0] dev, logic [31:0] a,
                                       logic [7:0] cnt, logic [IDX_W-1:0] j);
    logic [2:0] off;
    logic [7:0] val;
    off = OFF_DEVICE;
    val = dev;
    if (!wide) begin
      case (j)
        IDX_W'(0): begin off = OFF_DEVICE;  val = dev; end
        IDX_W'(1): begin off = OFF_COUNT;   val = cnt; end
        IDX_W'(2): begin off = OFF_LBA_LO;  val = a[7:0]; end
        IDX_W'(3): begin off = OFF_LBA_MID; val = a[15:8]; end
        IDX_W'(4): begin off = OFF_LBA_HI;  val = a[23:16]; end
        default:   begin off = OFF_DEVICE;  val = dev | {4'h0, a[27:24]}; end
      endcase
    end else begin
      case (j)
        IDX_W'(0): begin off = OFF_DEVICE;  val = dev; end
        IDX_W'(1): begin off = OFF_COUNT;   val = 8'h00; end
        IDX_W'(2): begin off = OFF_LBA_LO;  val = a[31:24]; end
        IDX_W'(3): begin off = OFF_LBA_MID; val = 8'h00; end
        IDX_W'(4): begin off = OFF_LBA_HI;  val = 8'h00; end
        IDX_W'(5): begin off = OFF_COUNT;   val = cnt; end
        IDX_W'(6): begin off = OFF_LBA_LO;  val = a[7:0]; end
        IDX_W'(7): begin off = OFF_LBA_MID; val = a[15:8]; end
        IDX_W'(8): begin off = OFF_LBA_HI;  val = a[23:16]; end
        default:   begin off = OFF_DEVICE;  val = dev; end
      endcase
    end
    return mk_result(OP_WRITE, off, {8'h00, val}, OC_OK, 8'h00);
  endfunction

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_select    <= 1'b0;
      wide_addressing <= 1'b0;
      highest_lba     <= 32'h0FFF_FFFF;
      poll_limit      <= POLL_W'(300000000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DRIVE:   drive_select    <= cfg_data[0];
        CFG_WIDE:    wide_addressing <= cfg_data[0];
        CFG_HIGHEST: highest_lba     <= cfg_data;
        CFG_POLL:    poll_limit      <= cfg_data[POLL_W-1:0];
        default:     drive_select    <= drive_select;
      endcase
    end
  end

  // input register; one queue slot is kept back for the item in it
  assign in_stall = (count >= CNT_W'(FIFO_ROOM));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid && !in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action <= action;
      s1_lba    <= lba;
      s1_cnt    <= sector_count;
      s1_status <= status_byte;
      s1_error  <= error_byte;
      s1_word   <= data_word;
    end
  end

  assign dev_byte = DEV_OBSOLETE | DEV_LBA | (drive_select ? DEV_SLAVE : 8'h00);

  // decode against the sequencer state and build the burst
  always_comb begin
    phase_next         = phase;
    write_pending_next = write_pending;
    flushing_next      = flushing;
    words_left_next    = words_left;
    polls_left_next    = polls_left;
    burst_next          = '0;
    burst_next.tail     = TAIL_NONE;
    burst_next.wide     = wide_addressing;
    burst_next.dev      = dev_byte;
    burst_next.lba      = s1_lba;
    burst_next.cnt      = s1_cnt;
    if (s1_valid) begin
      case (s1_action)
        ACT_READ, ACT_WRITE: begin
          if (phase == PH_IDLE) begin
            if (s1_lba > highest_lba) begin
              burst_next.has_lead = 1'b1;
              burst_next.lead = mk_result(OP_DONE, 3'd0, 16'h0, OC_RANGE, 8'h00);
            end else begin
              burst_next.tf   = 1'b1;
              burst_next.tail = TAIL_CMD;
              if (s1_action == ACT_WRITE) begin
                burst_next.cmd = wide_addressing ? CMD_WRITE_EXT : CMD_WRITE;
              end else begin
                burst_next.cmd = wide_addressing ? CMD_READ_EXT : CMD_READ;
              end
              words_left_next    = WORDS_W'(s1_cnt) * WORDS_W'(SECTOR_WORDS);
              write_pending_next = (s1_action == ACT_WRITE);
              flushing_next      = 1'b0;
              phase_next         = PH_SETTLE;
              polls_left_next    = POLL_W'(SETTLE_READS);
            end
          end
        end
        ACT_STATUS: begin
          if (phase == PH_SETTLE) begin
            // settle reads: answer discarded
            burst_next.has_lead = 1'b1;
            burst_next.lead = mk_result(OP_READ, OFF_CMD, 16'h0, OC_OK, 8'h00);
            if (polls_left > POLL_W'(1)) begin
              polls_left_next = polls_left - POLL_W'(1);
            end else begin
              phase_next      = PH_POLL;
              polls_left_next = poll_limit;
            end
          end else if (phase == PH_POLL) begin
            if (s1_status[ST_BSY]) begin
              burst_next.has_lead = 1'b1;
              if (polls_left <= POLL_W'(1)) begin
                burst_next.lead = mk_result(OP_DONE, 3'd0, 16'h0, OC_TIMEOUT, 8'h00);
                phase_next = PH_IDLE;
              end else begin
                burst_next.lead = mk_result(OP_READ, OFF_CMD, 16'h0, OC_OK, 8'h00);
                polls_left_next = polls_left - POLL_W'(1);
              end
            end else if (flushing) begin
              burst_next.has_lead = 1'b1;
              burst_next.lead = mk_result(OP_DONE, 3'd0, 16'h0, OC_OK, 8'h00);
              phase_next = PH_IDLE;
            end else if (s1_status[ST_ERR]) begin
              burst_next.has_lead = 1'b1;
              burst_next.lead = mk_result(OP_READ, OFF_ERROR, 16'h0, OC_OK, 8'h00);
              phase_next = PH_ERRWAIT;
            end else if (s1_status[ST_DF]) begin
              burst_next.has_lead = 1'b1;
              burst_next.lead = mk_result(OP_DONE, 3'd0, 16'h0, OC_FAULT, 8'h00);
              phase_next = PH_IDLE;
            end else if (!s1_status[ST_DRQ]) begin
              burst_next.has_lead = 1'b1;
              burst_next.lead = mk_result(OP_DONE, 3'd0, 16'h0, OC_NO_DRQ, 8'h00);
              phase_next = PH_IDLE;
            end else if (words_left == '0) begin
              // nothing to move: flush or complete right away
              if (write_pending) begin
                write_pending_next = 1'b0;
                flushing_next      = 1'b1;
                burst_next.tail    = TAIL_CMD;
                burst_next.cmd     = wide_addressing ? CMD_FLUSH_EXT : CMD_FLUSH;
                phase_next         = PH_SETTLE;
                polls_left_next    = POLL_W'(SETTLE_READS);
              end else begin
                burst_next.tail = TAIL_DONE;
                phase_next      = PH_IDLE;
              end
            end else begin
              phase_next = PH_XFER;
            end
          end
        end
        ACT_ERROR: begin
          if (phase == PH_ERRWAIT) begin
            burst_next.has_lead = 1'b1;
            burst_next.lead = mk_result(OP_DONE, 3'd0, 16'h0, OC_DEV_ERR, s1_error);
            phase_next = PH_IDLE;
          end
        end
        ACT_WORD: begin
          if (phase == PH_XFER && words_left != '0) begin
            burst_next.has_lead = 1'b1;
            if (write_pending) begin
              burst_next.lead = mk_result(OP_WRITE, OFF_DATA, s1_word, OC_OK, 8'h00);
            end else begin
              burst_next.lead = mk_result(OP_HOST, 3'd0, s1_word, OC_OK, 8'h00);
            end
            words_left_next = words_left - WORDS_W'(1);
            if (words_left == WORDS_W'(1)) begin
              if (write_pending) begin
                write_pending_next = 1'b0;
                flushing_next      = 1'b1;
                burst_next.tail    = TAIL_CMD;
                burst_next.cmd     = wide_addressing ? CMD_FLUSH_EXT : CMD_FLUSH;
                phase_next         = PH_SETTLE;
                polls_left_next    = POLL_W'(SETTLE_READS);
              end else begin
                burst_next.tail = TAIL_DONE;
                phase_next      = PH_IDLE;
              end
            end
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
      // every completion returns the sequencer to a clean idle
      if (phase_next == PH_IDLE) begin
        write_pending_next = 1'b0;
        flushing_next      = 1'b0;
        words_left_next    = '0;
        polls_left_next    = '0;
      end
    end
  end

  assign push = burst_next.has_lead || burst_next.tf || (burst_next.tail != TAIL_NONE);

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      write_pending <= 1'b0;
      flushing      <= 1'b0;
      words_left    <= '0;
      polls_left    <= '0;
    end else begin
      phase         <= phase_next;
      write_pending <= write_pending_next;
      flushing      <= flushing_next;
      words_left    <= words_left_next;
      polls_left    <= polls_left_next;
    end
  end

  // burst queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= burst_next;
    end
  end

  // burst queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // walk the head burst one result per cycle while out_stall is low
  assign head      = fifo[rd_ptr];
  assign out_valid = (count != '0);
  assign lead_len  = head.has_lead ? IDX_W'(1) : IDX_W'(0);
  assign tf_len    = !head.tf ? IDX_W'(0) :
                     (head.wide ? IDX_W'(TF_LEN_WIDE) : IDX_W'(TF_LEN_NARROW));
  assign tail_len  = (head.tail == TAIL_CMD) ? IDX_W'(2) :
                     ((head.tail == TAIL_DONE) ? IDX_W'(1) : IDX_W'(0));
  assign burst_len = lead_len + tf_len + tail_len;
  assign rel       = idx - lead_len;
  assign rel_tail  = rel - tf_len;
  assign is_last   = (idx == burst_len - IDX_W'(1));
  assign pop       = out_valid && !out_stall && is_last;

  always_comb begin
    if (head.has_lead && idx == '0) begin
      cur = head.lead;
    end else if (head.tf && rel < tf_len) begin
      cur = tf_entry(head.wide, head.dev, head.lba, head.cnt, rel);
    end else if (head.tail == TAIL_DONE) begin
      cur = mk_result(OP_DONE, 3'd0, 16'h0, OC_OK, 8'h00);
    end else if (rel_tail == '0) begin
      cur = mk_result(OP_WRITE, OFF_CMD, {8'h00, head.cmd}, OC_OK, 8'h00);
    end else begin
      cur = mk_result(OP_READ, OFF_CMD, 16'h0, OC_OK, 8'h00);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_valid && !out_stall) begin
      idx <= is_last ? '0 : idx + IDX_W'(1);
    end
  end

  assign bus_op      = cur.op;
  assign port_offset = cur.off;
  assign bus_value   = cur.value;
  assign outcome     = cur.outcome;
  assign error_bits  = cur.err;
  assign last_of_run = is_last;

  // checks
  `ATA_ASSERT_NOW(a_push_room, push, count < CNT_W'(FIFO_DEPTH), "burst queue overflow")
  `ATA_ASSERT_NOW(a_idx_in_burst, out_valid, idx < burst_len, "walker past burst end")
  `ATA_ASSERT_NOW(a_done_is_last, out_valid && bus_op == OP_DONE, last_of_run, "completion not last")
  `ATA_ASSERT_NOW(a_idle_clean, phase == PH_IDLE, words_left == '0 && !write_pending && !flushing, "idle with leftover state")
  `ATA_ASSERT_NEXT(a_accept_loads, in_valid && !in_stall, s1_valid, "accepted item not registered")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Random and directed test of the ata pio command sequencer. A tracker class
// follows the sequencer state from every accepted input transaction, queues
// the bus transactions it should produce and checks each one on the output.
// ----------------------------------------------------------------------------
import ata_pkg::*;

// one expected or observed bus transaction
typedef struct packed {
  logic [1:0]  op;
  logic [2:0]  off;
  logic [15:0] value;
  logic [2:0]  oc;
  logic [7:0]  err;
  logic        last;
} bus_txn_t;

class ata_sequence_tracker;
  // register copy
  logic        slave_sel;
  logic        wide_mode;
  logic [31:0] lba_ceiling;
  logic [28:0] poll_budget;
  // sequencer state
  phase_t      ph;
  logic        write_pend;
  logic        flush_active;
  int unsigned words_left;
  int unsigned polls_left;
  // bus transactions still owed by the block
  bus_txn_t    pending_bus_ops[$];
  int          burst_len;
  int          mismatches;

  function new();
    slave_sel    = 1'b0;
    wide_mode    = 1'b0;
    lba_ceiling  = 32'h0FFF_FFFF;
    poll_budget  = 29'd300_000_000;
    ph           = PH_IDLE;
    write_pend   = 1'b0;
    flush_active = 1'b0;
    words_left   = 0;
    polls_left   = 0;
    mismatches   = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      CFG_DRIVE:   slave_sel   = data[0];
      CFG_WIDE:    wide_mode   = data[0];
      CFG_HIGHEST: lba_ceiling = data;
      CFG_POLL:    poll_budget = data[28:0];
      default: ;
    endcase
  endfunction

  function void add_txn(logic [1:0] op, logic [2:0] off, logic [15:0] value,
                        logic [2:0] oc = OC_OK, logic [7:0] err = 8'h00);
    bus_txn_t t;
    t.op    = op;
    t.off   = off;
    t.value = value;
    t.oc    = oc;
    t.err   = err;
    t.last  = 1'b0;
    pending_bus_ops.push_back(t);
    burst_len++;
  endfunction

  // completion transaction, back to idle
  function void conclude(logic [2:0] oc, logic [7:0] err);
    add_txn(OP_DONE, OFF_DATA, 16'h0000, oc, err);
    ph           = PH_IDLE;
    write_pend   = 1'b0;
    flush_active = 1'b0;
    words_left   = 0;
    polls_left   = 0;
  endfunction

  // command write followed by the first settle read
  function void issue_cmd(logic [7:0] cmd);
    add_txn(OP_WRITE, OFF_CMD, {8'h00, cmd});
    add_txn(OP_READ, OFF_CMD, 16'h0000);
    ph         = PH_SETTLE;
    polls_left = SETTLE_READS;
  endfunction

  function void data_done();
    if (write_pend) begin
      write_pend   = 1'b0;
      flush_active = 1'b1;
      issue_cmd(wide_mode ? CMD_FLUSH_EXT : CMD_FLUSH);
    end else begin
      conclude(OC_OK, 8'h00);
    end
  endfunction

  function void start_request(logic [31:0] addr, logic [7:0] cnt, logic wr);
    logic [7:0] dev;
    dev = DEV_OBSOLETE | DEV_LBA | (slave_sel ? DEV_SLAVE : 8'h00);
    if (addr > lba_ceiling) begin
      conclude(OC_RANGE, 8'h00);
      return;
    end
    add_txn(OP_WRITE, OFF_DEVICE, {8'h00, dev});
    if (!wide_mode) begin
      // lba28: only bits 27..24 reach the head nibble
      add_txn(OP_WRITE, OFF_COUNT, {8'h00, cnt});
      add_txn(OP_WRITE, OFF_LBA_LO, {8'h00, addr[7:0]});
      add_txn(OP_WRITE, OFF_LBA_MID, {8'h00, addr[15:8]});
      add_txn(OP_WRITE, OFF_LBA_HI, {8'h00, addr[23:16]});
      add_txn(OP_WRITE, OFF_DEVICE, {8'h00, dev | {4'h0, addr[27:24]}});
    end else begin
      // lba48: high bytes first, address bits above 31 are zero
      add_txn(OP_WRITE, OFF_COUNT, 16'h0000);
      add_txn(OP_WRITE, OFF_LBA_LO, {8'h00, addr[31:24]});
      add_txn(OP_WRITE, OFF_LBA_MID, 16'h0000);
      add_txn(OP_WRITE, OFF_LBA_HI, 16'h0000);
      add_txn(OP_WRITE, OFF_COUNT, {8'h00, cnt});
      add_txn(OP_WRITE, OFF_LBA_LO, {8'h00, addr[7:0]});
      add_txn(OP_WRITE, OFF_LBA_MID, {8'h00, addr[15:8]});
      add_txn(OP_WRITE, OFF_LBA_HI, {8'h00, addr[23:16]});
      add_txn(OP_WRITE, OFF_DEVICE, {8'h00, dev});
    end
    words_left   = cnt * SECTOR_WORDS;
    write_pend   = wr;
    flush_active = 1'b0;
    if (!wide_mode) begin
      issue_cmd(wr ? CMD_WRITE : CMD_READ);
    end else begin
      issue_cmd(wr ? CMD_WRITE_EXT : CMD_READ_EXT);
    end
  endfunction

  function void take_status(logic [7:0] st);
    if (ph == PH_SETTLE) begin
      if (polls_left > 1) begin
        polls_left--;
      end else begin
        ph         = PH_POLL;
        polls_left = poll_budget;
      end
      add_txn(OP_READ, OFF_CMD, 16'h0000);
    end else if (st[ST_BSY]) begin
      // a zero budget still allows one poll
      if (polls_left <= 1) begin
        conclude(OC_TIMEOUT, 8'h00);
      end else begin
        polls_left--;
        add_txn(OP_READ, OFF_CMD, 16'h0000);
      end
    end else if (flush_active) begin
      conclude(OC_OK, 8'h00);
    end else if (st[ST_ERR]) begin
      ph = PH_ERRWAIT;
      add_txn(OP_READ, OFF_ERROR, 16'h0000);
    end else if (st[ST_DF]) begin
      conclude(OC_FAULT, 8'h00);
    end else if (!st[ST_DRQ]) begin
      conclude(OC_NO_DRQ, 8'h00);
    end else if (words_left == 0) begin
      data_done();
    end else begin
      ph = PH_XFER;
    end
  endfunction

  function void take_word(logic [15:0] w);
    add_txn(write_pend ? OP_WRITE : OP_HOST, OFF_DATA, w);
    words_left--;
    if (words_left == 0) begin
      data_done();
    end
  endfunction

  // whether an action has any effect in the present phase
  function bit accepts(logic [2:0] act);
    case (act)
      ACT_READ, ACT_WRITE: return ph == PH_IDLE;
      ACT_STATUS:          return ph == PH_SETTLE || ph == PH_POLL;
      ACT_ERROR:           return ph == PH_ERRWAIT;
      ACT_WORD:            return ph == PH_XFER && words_left != 0;
      default:             return 1'b0;
    endcase
  endfunction

  // note one accepted input transaction
  function void take_item(logic [2:0] act, logic [31:0] addr, logic [7:0] cnt,
                          logic [7:0] st, logic [7:0] eb, logic [15:0] w);
    bus_txn_t tail;
    burst_len = 0;
    if (accepts(act)) begin
      case (act)
        ACT_READ, ACT_WRITE: start_request(addr, cnt, act == ACT_WRITE);
        ACT_STATUS:          take_status(st);
        ACT_ERROR:           conclude(OC_DEV_ERR, eb);
        default:             take_word(w);
      endcase
    end
    if (burst_len > 0) begin
      tail      = pending_bus_ops.pop_back();
      tail.last = 1'b1;
      pending_bus_ops.push_back(tail);
    end
  endfunction

  task flag_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // compare one output transaction with the oldest owed one
  task check_bus_result(bus_txn_t got);
    bus_txn_t want;
    if (pending_bus_ops.size() == 0) begin
      flag_mismatch($sformatf("unexpected op %0d off %0d value %h outcome %0d",
                              got.op, got.off, got.value, got.oc));
    end else begin
      want = pending_bus_ops.pop_front();
      if (got.op !== want.op || got.off !== want.off || got.value !== want.value ||
          got.oc !== want.oc || got.err !== want.err || got.last !== want.last) begin
        flag_mismatch($sformatf(
          "got/want op %0d/%0d off %0d/%0d value %h/%h outcome %0d/%0d err %h/%h last %0b/%0b",
          got.op, want.op, got.off, want.off, got.value, want.value,
          got.oc, want.oc, got.err, want.err, got.last, want.last));
      end
    end
  endtask
endclass

module testbench;
  localparam int         DRAIN_CYCLES = 16;
  localparam logic [2:0] ACT_SPARE    = 3'd7;

  typedef enum {
    FATE_OK,
    FATE_RANGE,
    FATE_DEV_ERR,
    FATE_FAULT,
    FATE_NO_DRQ,
    FATE_TIMEOUT,
    FATE_WILD
  } op_fate_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index    = CFG_DRIVE;
  logic [31:0] cfg_data     = '0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [2:0]  action       = ACT_READ;
  logic [31:0] lba          = '0;
  logic [7:0]  sector_count = '0;
  logic [7:0]  status_byte  = '0;
  logic [7:0]  error_byte   = '0;
  logic [15:0] data_word    = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [1:0]  bus_op;
  logic [2:0]  port_offset;
  logic [15:0] bus_value;
  logic [2:0]  outcome;
  logic [7:0]  error_bits;
  logic        last_of_run;

  ata_sequence_tracker tracker = new();
  bit no_idle           = 1'b0;
  bit full_transfer_due = 1'b0;
  int cmd_items         = 0;

  ata_pio_command_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .lba          (lba),
    .sector_count (sector_count),
    .status_byte  (status_byte),
    .error_byte   (error_byte),
    .data_word    (data_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bus_op       (bus_op),
    .port_offset  (port_offset),
    .bus_value    (bus_value),
    .outcome      (outcome),
    .error_bits   (error_bits),
    .last_of_run  (last_of_run)
  );

  always #1 clk = ~clk;

  // random back pressure on the result side
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < 21);
  end

  // check every result transaction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.check_bus_result(
        bus_txn_t'({bus_op, port_offset, bus_value, outcome, error_bits, last_of_run}));
    end
  end

  // present one input transaction, hold it until taken
  task automatic send_item(logic [2:0] act, logic [31:0] addr, logic [7:0] cnt,
                           logic [7:0] st, logic [7:0] eb, logic [15:0] w);
    while (!no_idle && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    lba          <= addr;
    sector_count <= cnt;
    status_byte  <= st;
    error_byte   <= eb;
    data_word    <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_item(act, addr, cnt, st, eb, w);
    if (act != ACT_WORD) begin
      cmd_items++;
    end
  endtask

  task automatic send_act(logic [2:0] act, logic [7:0] st);
    send_item(act, $urandom, 8'($urandom), st, 8'($urandom), 16'($urandom));
  endtask

  // a transaction the block must drop in its present phase
  task automatic send_stray();
    logic [2:0] act;
    do begin
      act = 3'($urandom);
    end while (tracker.accepts(act));
    send_act(act, 8'($urandom));
  endtask

  task automatic load_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic program_regs(logic drive, logic wide, logic [31:0] ceiling,
                              logic [28:0] polls);
    load_reg(CFG_DRIVE, {31'd0, drive});
    load_reg(CFG_WIDE, {31'd0, wide});
    load_reg(CFG_HIGHEST, ceiling);
    load_reg(CFG_POLL, {3'd0, polls});
    cfg_valid <= 1'b0;
  endtask

  // stop input, wait for all owed transactions and let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.pending_bus_ops.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sector count for a request that reaches the data phase
  function automatic logic [7:0] transfer_count();
    int r;
    if (full_transfer_due) begin
      full_transfer_due = 1'b0;
      return 8'd255;
    end
    r = $urandom_range(99);
    if (r < 30) return 8'd0;
    if (r < 75) return 8'd1;
    return 8'($urandom_range(3, 2));
  endfunction

  // one request from start to completion, with strays mixed in
  task automatic run_operation();
    op_fate_t    fate;
    logic        wr;
    logic [31:0] addr;
    logic [7:0]  cnt;
    logic [7:0]  st;
    int          r;
    int          busy_left;
    bit          flush_hang;
    r = $urandom_range(99);
    fate = r < 30 ? FATE_OK : r < 40 ? FATE_RANGE : r < 50 ? FATE_DEV_ERR :
           r < 58 ? FATE_FAULT : r < 66 ? FATE_NO_DRQ : r < 76 ? FATE_TIMEOUT : FATE_WILD;
    if (fate == FATE_RANGE && tracker.lba_ceiling == 32'hFFFF_FFFF) fate = FATE_OK;
    if (fate == FATE_TIMEOUT && tracker.poll_budget > 8) fate = FATE_DEV_ERR;
    wr  = 1'($urandom_range(1));
    cnt = (fate == FATE_OK || fate == FATE_WILD) ? transfer_count() : 8'($urandom);
    if (fate == FATE_RANGE) begin
      addr = $urandom_range(3) == 0 ? tracker.lba_ceiling + 32'd1 :
             $urandom_range(32'hFFFF_FFFF, tracker.lba_ceiling + 32'd1);
    end else if (tracker.lba_ceiling == 32'hFFFF_FFFF) begin
      addr = $urandom;
    end else if ($urandom_range(3) == 0) begin
      addr = tracker.lba_ceiling;
    end else begin
      addr = $urandom_range(tracker.lba_ceiling, 0);
    end
    busy_left  = $urandom_range(3);
    flush_hang = fate == FATE_OK && tracker.poll_budget <= 8 && $urandom_range(3) == 0;

    if ($urandom_range(99) < 8) send_stray();
    send_item(wr ? ACT_WRITE : ACT_READ, addr, cnt, 8'($urandom), 8'($urandom),
              16'($urandom));
    while (tracker.ph != PH_IDLE) begin
      if ($urandom_range(99) < 6) begin
        send_stray();
      end else begin
        st = 8'($urandom);
        case (tracker.ph)
          PH_SETTLE: send_act(ACT_STATUS, st);
          PH_POLL: begin
            // shape the poll answer toward the planned ending
            if (fate == FATE_TIMEOUT || (flush_hang && tracker.flush_active)) begin
              st[ST_BSY] = 1'b1;
            end else if (fate != FATE_WILD) begin
              st[ST_BSY] = busy_left > 0 && tracker.polls_left > 1;
              if (st[ST_BSY]) begin
                busy_left--;
              end else if (!tracker.flush_active) begin
                st[ST_ERR] = fate == FATE_DEV_ERR;
                st[ST_DF]  = fate == FATE_FAULT;
                st[ST_DRQ] = fate == FATE_OK;
              end
            end
            send_act(ACT_STATUS, st);
          end
          PH_ERRWAIT: send_act(ACT_ERROR, st);
          default:    send_act(ACT_WORD, st);
        endcase
      end
    end
  endtask

  initial begin
    logic [31:0] ceiling;
    logic [28:0] polls;
    int          target;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // slave, lba28, full range, zero poll budget
    program_regs(1'b1, 1'b0, 32'hFFFF_FFFF, 29'd0);
    // top address drops its upper nibble, first busy poll times out
    send_item(ACT_READ, 32'hFFFF_FFFF, 8'd255, 8'h00, 8'h00, 16'h0000);
    repeat (SETTLE_READS) send_item(ACT_STATUS, '0, '0, 8'hFF, 8'h00, 16'h0000);
    send_item(ACT_STATUS, '0, '0, 8'(1 << ST_BSY), 8'h00, 16'h0000);
    // zero sectors on a write still flushes; flush looks at busy only
    send_item(ACT_WRITE, 32'h0000_0000, 8'd0, 8'h00, 8'h00, 16'h0000);
    repeat (SETTLE_READS) send_item(ACT_STATUS, '0, '0, 8'h00, 8'h00, 16'h0000);
    send_item(ACT_STATUS, '0, '0, 8'(1 << ST_DRQ), 8'h00, 16'h0000);
    repeat (SETTLE_READS) send_item(ACT_STATUS, '0, '0, 8'h00, 8'h00, 16'h0000);
    send_item(ACT_STATUS, '0, '0, 8'h7F, 8'h00, 16'h0000);
    // out of phase while idle, and an unused action code
    send_item(ACT_STATUS, '0, '0, 8'h00, 8'h00, 16'h0000);
    send_item(ACT_ERROR, '0, '0, 8'h00, 8'hFF, 16'h0000);
    send_item(ACT_WORD, '0, '0, 8'h00, 8'h00, 16'hFFFF);
    send_item(ACT_SPARE, 32'h0000_0000, 8'd1, 8'h00, 8'h00, 16'h0000);
    drain_results();

    // master, lba48, only sector zero allowed
    program_regs(1'b0, 1'b1, 32'h0000_0000, 29'd1);
    send_item(ACT_READ, 32'h0000_0001, 8'd1, 8'h00, 8'h00, 16'h0000);
    // device error before data on a write: no flush
    send_item(ACT_WRITE, 32'h0000_0000, 8'd1, 8'h00, 8'h00, 16'h0000);
    repeat (SETTLE_READS) send_item(ACT_STATUS, '0, '0, 8'h00, 8'h00, 16'h0000);
    send_item(ACT_STATUS, '0, '0, 8'(1 << ST_ERR), 8'h00, 16'h0000);
    send_item(ACT_ERROR, '0, '0, 8'h00, 8'hFF, 16'h0000);

    // random operations under a range of register settings
    for (int p = 0; p < 8; p++) begin
      drain_results();
      no_idle = p == 3;
      case ((p + p / 4) % 4)
        0:       ceiling = 32'hFFFF_FFFF;
        1:       ceiling = 32'h0FFF_FFFF;
        2:       ceiling = 32'h0000_0000;
        default: ceiling = $urandom;
      endcase
      case (p)
        0, 3:    polls = 29'd300_000_000;
        1, 4:    polls = 29'($urandom_range(8, 2));
        2, 7:    polls = 29'd1;
        5:       polls = 29'd0;
        default: polls = 29'($urandom_range(3000, 9));
      endcase
      full_transfer_due = p == 6;
      program_regs(p[0], p[1], ceiling, polls);
      target = cmd_items + 58;
      while (cmd_items < target) run_operation();
    end
    no_idle = 1'b0;
    drain_results();

    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run time limit
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
